/* rtl/gscs_pkg.sv */
package gscs_pkg;

	// fixed field widths
	localparam int CFG_W  = 16;
	localparam int DUTY_W = 8;
	localparam int GEAR_W = 2;
	localparam int IDX_W  = 2;

	// default timer width, range 8 to 32
	localparam int TIMER_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SHIFT_DELAY   = 2'd0;
	localparam logic [IDX_W-1:0] REG_RELEASE_DELAY = 2'd1;
	localparam logic [IDX_W-1:0] REG_ENGAGE_DELAY  = 2'd2;
	localparam logic [IDX_W-1:0] REG_DUTY_MAX      = 2'd3;

	// configuration reset values
	localparam logic [CFG_W-1:0]  SHIFT_DELAY_RST   = 16'd15625;
	localparam logic [CFG_W-1:0]  RELEASE_DELAY_RST = 16'd15625;
	localparam logic [CFG_W-1:0]  ENGAGE_DELAY_RST  = 16'd15625;
	localparam logic [DUTY_W-1:0] DUTY_MAX_RST      = 8'd153;

	// gear codes
	localparam logic [GEAR_W-1:0] GEAR_1ST = 2'd0;
	localparam logic [GEAR_W-1:0] GEAR_2ND = 2'd1;
	localparam logic [GEAR_W-1:0] GEAR_3RD = 2'd2;
	localparam logic [GEAR_W-1:0] GEAR_4TH = 2'd3;

	// request types
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;    // latch the input transaction
		logic step;      // run one sequencing step
		logic mul;       // register count * duty_max
		logic div_load;  // seed the divider
		logic div_step;  // one quotient bit
		logic out_load;  // fill the result register
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;  // last quotient bit in this cycle
	} dp_stat_t;

endpackage

/* rtl/gscs_ctrl.sv */
module gscs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  gscs_pkg::dp_stat_t stat,
	output gscs_pkg::dp_cmd_t  cmd
);
	import gscs_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_STEP;
			ST_STEP: state_n = ST_MUL;
			ST_MUL:  state_n = ST_LOAD;
			ST_LOAD: state_n = ST_DIV;
			ST_DIV:  if (stat.div_done) state_n = ST_DONE;
			ST_DONE: if (slot_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_STEP: cmd.step     = 1'b1;
			ST_MUL:  cmd.mul      = 1'b1;
			ST_LOAD: cmd.div_load = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_DONE: cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/gscs_dp.sv */
module gscs_dp #(
	parameter int TIMER_BITS = gscs_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gscs_pkg::dp_cmd_t             cmd,
	output gscs_pkg::dp_stat_t            stat,
	input  logic                          cfg_we,
	input  logic [gscs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gscs_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          req_type,
	input  logic [gscs_pkg::GEAR_W-1:0]   cmd_gear,
	input  logic                          cmd_clutch,
	input  logic                          enabled,
	output logic                          solenoid_a,
	output logic                          solenoid_b,
	output logic [gscs_pkg::DUTY_W-1:0]   clutch_pwm,
	output logic                          clutch_drive_on,
	output logic [gscs_pkg::GEAR_W-1:0]   gear_now,
	output logic                          clutch_now,
	output logic                          busy_res,
	output logic [gscs_pkg::GEAR_W-1:0]   status_gear,
	output logic                          status_clutch,
	output logic                          status_enabled
);
	import gscs_pkg::*;

	localparam int PROD_W = TIMER_BITS + DUTY_W;
	localparam int DCNT_W = $clog2(DUTY_W);

	// configuration
	logic [CFG_W-1:0]  shift_dly_q;
	logic [CFG_W-1:0]  release_dly_q;
	logic [CFG_W-1:0]  engage_dly_q;
	logic [DUTY_W-1:0] duty_max_q;

	// latched input transaction
	logic              req_q;
	logic [GEAR_W-1:0] cmd_gear_q;
	logic              cmd_clutch_q;
	logic              en_q;

	// sequencer state
	logic [GEAR_W-1:0]     gear_q, gear_n;
	logic                  clutch_q, clutch_n;
	logic [GEAR_W-1:0]     dgear_q, dgear_n;
	logic                  dclutch_q, dclutch_n;
	logic                  block_q, block_n;
	logic                  run_q, run_n;
	logic [TIMER_BITS-1:0] cnt_q, cnt_n;
	logic [TIMER_BITS-1:0] lim_q, lim_n;
	logic [TIMER_BITS-1:0] cnt_inc;

	logic             start;
	logic [CFG_W-1:0] start_ticks;
	logic             start_block;

	// ramp divider
	logic [PROD_W-1:0]     prod_q;
	logic [TIMER_BITS-1:0] rem_q;
	logic [DUTY_W-1:0]     quo_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic [TIMER_BITS:0]   trial;
	logic                  trial_ge;
	logic [TIMER_BITS:0]   trial_sub;
	logic [DUTY_W-1:0]     duty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_dly_q   <= SHIFT_DELAY_RST;
			release_dly_q <= RELEASE_DELAY_RST;
			engage_dly_q  <= ENGAGE_DELAY_RST;
			duty_max_q    <= DUTY_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHIFT_DELAY:   shift_dly_q   <= cfg_wdata;
				REG_RELEASE_DELAY: release_dly_q <= cfg_wdata;
				REG_ENGAGE_DELAY:  engage_dly_q  <= cfg_wdata;
				REG_DUTY_MAX:      duty_max_q    <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q        <= req_type;
			cmd_gear_q   <= cmd_gear;
			cmd_clutch_q <= cmd_clutch;
			en_q         <= enabled;
		end
	end

	assign cnt_inc = cnt_q + TIMER_BITS'(1);

	always_comb begin
		gear_n      = gear_q;
		clutch_n    = clutch_q;
		dgear_n     = dgear_q;
		dclutch_n   = dclutch_q;
		block_n     = block_q;
		run_n       = run_q;
		cnt_n       = cnt_q;
		lim_n       = lim_q;
		start       = 1'b0;
		start_ticks = shift_dly_q;
		start_block = 1'b0;

		if (req_q == REQ_TICK) begin
			if (run_q) begin
				cnt_n = cnt_inc;
				if (cnt_inc >= lim_q) begin
					run_n   = 1'b0;
					lim_n   = '0;
					block_n = 1'b0;
				end
			end
		end else begin
			dgear_n   = cmd_gear_q;
			dclutch_n = cmd_clutch_q;
		end

		// no lockup in first gear or while disabled
		if (!en_q || dgear_n == GEAR_1ST)
			dclutch_n = 1'b0;

		if (!block_n) begin
			if (gear_q != dgear_n) begin
				start       = 1'b1;
				start_block = 1'b1;
				if (clutch_q) begin
					clutch_n    = 1'b0;
					start_ticks = release_dly_q;
				end else begin
					gear_n      = dgear_n;
					start_ticks = shift_dly_q;
				end
			end else if (clutch_q != dclutch_n) begin
				clutch_n = dclutch_n;
				start    = 1'b1;
				if (dclutch_n) begin
					start_ticks = engage_dly_q;
					start_block = 1'b0;
				end else begin
					start_ticks = release_dly_q;
					start_block = 1'b1;
				end
			end
		end

		if (start) begin
			block_n = start_block;
			lim_n   = TIMER_BITS'(start_ticks);
			cnt_n   = '0;
			run_n   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q    <= GEAR_2ND;
			clutch_q  <= 1'b0;
			dgear_q   <= GEAR_2ND;
			dclutch_q <= 1'b0;
			block_q   <= 1'b0;
			run_q     <= 1'b0;
			cnt_q     <= '0;
			lim_q     <= '0;
		end else if (cmd.step) begin
			gear_q    <= gear_n;
			clutch_q  <= clutch_n;
			dgear_q   <= dgear_n;
			dclutch_q <= dclutch_n;
			block_q   <= block_n;
			run_q     <= run_n;
			cnt_q     <= cnt_n;
			lim_q     <= lim_n;
		end
	end

	// restoring division, quotient known to fit in DUTY_W bits
	assign trial     = {rem_q, quo_q[DUTY_W-1]};
	assign trial_ge  = trial >= {1'b0, lim_q};
	assign trial_sub = trial - {1'b0, lim_q};

	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= PROD_W'(cnt_q) * PROD_W'(duty_max_q);
		if (cmd.div_load) begin
			rem_q <= prod_q[PROD_W-1:DUTY_W];
			quo_q <= prod_q[DUTY_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[TIMER_BITS-1:0] : trial[TIMER_BITS-1:0];
			quo_q <= {quo_q[DUTY_W-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dcnt_q <= '0;
		else if (cmd.div_load)
			dcnt_q <= '0;
		else if (cmd.div_step)
			dcnt_q <= dcnt_q + DCNT_W'(1);
	end

	assign stat.div_done = cmd.div_step && (dcnt_q == DCNT_W'(DUTY_W - 1));

	always_comb begin
		if (!clutch_q)
			duty = '0;
		else if (!run_q || lim_q == '0)
			duty = duty_max_q;
		else
			duty = quo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			solenoid_a      <= (gear_q == GEAR_1ST) || (gear_q == GEAR_2ND);
			solenoid_b      <= (gear_q == GEAR_2ND) || (gear_q == GEAR_3RD);
			clutch_pwm      <= duty;
			clutch_drive_on <= (duty != '0);
			gear_now        <= gear_q;
			clutch_now      <= clutch_q;
			busy_res        <= block_q;
			status_gear     <= dgear_q;
			status_clutch   <= dclutch_q;
			status_enabled  <= en_q;
		end
	end

endmodule

/* rtl/gear_shift_clutch_sequencer_top.sv */
// A new input transaction is taken only in idle, once the previous result has been
// loaded; each transaction runs through the 8-step restoring divider of the duty ramp.
// A finished result waits in the output register while the next input transaction
// is taken. Reset (arst_n low) returns the sequencer to second gear, clutch released,
// timer stopped, and the delay and duty registers to defaults.
module gear_shift_clutch_sequencer_top #(
	parameter int TIMER_BITS = gscs_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [gscs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gscs_pkg::CFG_W-1:0]    cfg_wdata,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [gscs_pkg::GEAR_W-1:0]   cmd_gear,
	input  logic                          cmd_clutch,
	input  logic                          enabled,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          solenoid_a,
	output logic                          solenoid_b,
	output logic [gscs_pkg::DUTY_W-1:0]   clutch_pwm,
	output logic                          clutch_drive_on,
	output logic [gscs_pkg::GEAR_W-1:0]   gear_now,
	output logic                          clutch_now,
	output logic                          busy_res,
	output logic [gscs_pkg::GEAR_W-1:0]   status_gear,
	output logic                          status_clutch,
	output logic                          status_enabled
);
	import gscs_pkg::*;

	// Controller walks each transaction through: latch, sequencing step,
	// multiply count by duty_max, seed divider, eight quotient bits, result load.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	gscs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath holds the config registers, gear/clutch/timer state, the
	// ramp multiplier and divider, and the result register.
	gscs_dp #(
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_type        (req_type),
		.cmd_gear        (cmd_gear),
		.cmd_clutch      (cmd_clutch),
		.enabled         (enabled),
		.solenoid_a      (solenoid_a),
		.solenoid_b      (solenoid_b),
		.clutch_pwm      (clutch_pwm),
		.clutch_drive_on (clutch_drive_on),
		.gear_now        (gear_now),
		.clutch_now      (clutch_now),
		.busy_res        (busy_res),
		.status_gear     (status_gear),
		.status_clutch   (status_clutch),
		.status_enabled  (status_enabled)
	);

endmodule

/* tb/gscs_checker.sv */
`timescale 1ns / 100ps

module gscs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gscs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gscs_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          req_type,
	input  logic [gscs_pkg::GEAR_W-1:0]   cmd_gear,
	input  logic                          cmd_clutch,
	input  logic                          enabled,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          solenoid_a,
	input  logic                          solenoid_b,
	input  logic [gscs_pkg::DUTY_W-1:0]   clutch_pwm,
	input  logic                          clutch_drive_on,
	input  logic [gscs_pkg::GEAR_W-1:0]   gear_now,
	input  logic                          clutch_now,
	input  logic                          busy_res,
	input  logic [gscs_pkg::GEAR_W-1:0]   status_gear,
	input  logic                          status_clutch,
	input  logic                          status_enabled,
	output int                            fail_count,
	output int                            pending_count
);
	import gscs_pkg::*;

	typedef struct packed {
		logic              sol_a;
		logic              sol_b;
		logic [DUTY_W-1:0] duty;
		logic              drive_on;
		logic [GEAR_W-1:0] gear;
		logic              clutch;
		logic              busy;
		logic [GEAR_W-1:0] want_gear;
		logic              want_clutch;
		logic              en;
	} shift_status_t;

	shift_status_t pending_status[$];
	int            fails;

	// register copies
	logic [CFG_W-1:0]  shift_dly;
	logic [CFG_W-1:0]  release_dly;
	logic [CFG_W-1:0]  engage_dly;
	logic [DUTY_W-1:0] duty_full;

	// sequencer state
	logic [GEAR_W-1:0] cur_gear;
	logic              cur_clutch;
	logic [GEAR_W-1:0] want_gear;
	logic              want_clutch;
	logic              blocked;
	logic              tmr_run;
	logic [15:0]       tmr_count;
	logic [15:0]       tmr_limit;

	task automatic start_timer(input logic [15:0] ticks, input logic block);
		blocked   = block;
		tmr_limit = ticks;
		tmr_count = '0;
		tmr_run   = 1'b1;
	endtask

	task automatic sequence_step(input logic rt, input logic [GEAR_W-1:0] g, input logic c,
			input logic en, output shift_status_t res);
		logic [23:0]       prod;
		logic [DUTY_W-1:0] duty;
		if (rt == REQ_TICK) begin
			if (tmr_run) begin
				tmr_count = tmr_count + 16'd1;
				if (tmr_count >= tmr_limit) begin
					tmr_run   = 1'b0;
					tmr_limit = '0;
					blocked   = 1'b0;
				end
			end
		end else begin
			want_gear   = g;
			want_clutch = c;
		end
		// no lockup in first gear or while disabled
		if (!en || want_gear == GEAR_1ST)
			want_clutch = 1'b0;
		if (!blocked) begin
			if (cur_gear != want_gear) begin
				// release first, shift on a later step
				if (cur_clutch) begin
					cur_clutch = 1'b0;
					start_timer(release_dly, 1'b1);
				end else begin
					cur_gear = want_gear;
					start_timer(shift_dly, 1'b1);
				end
			end else if (cur_clutch != want_clutch) begin
				cur_clutch = want_clutch;
				if (want_clutch)
					start_timer(engage_dly, 1'b0);
				else
					start_timer(release_dly, 1'b1);
			end
		end
		if (!cur_clutch) begin
			duty = '0;
		end else if (!tmr_run || tmr_limit == 16'd0) begin
			duty = duty_full;
		end else begin
			prod = {8'd0, tmr_count} * {16'd0, duty_full};
			duty = DUTY_W'(prod / {8'd0, tmr_limit});
		end
		res.sol_a       = (cur_gear == GEAR_1ST) || (cur_gear == GEAR_2ND);
		res.sol_b       = (cur_gear == GEAR_2ND) || (cur_gear == GEAR_3RD);
		res.duty        = duty;
		res.drive_on    = (duty != '0);
		res.gear        = cur_gear;
		res.clutch      = cur_clutch;
		res.busy        = blocked;
		res.want_gear   = want_gear;
		res.want_clutch = want_clutch;
		res.en          = en;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		shift_status_t res;
		shift_status_t exp;
		if (!arst_n) begin
			shift_dly   = SHIFT_DELAY_RST;
			release_dly = RELEASE_DELAY_RST;
			engage_dly  = ENGAGE_DELAY_RST;
			duty_full   = DUTY_MAX_RST;
			cur_gear    = GEAR_2ND;
			cur_clutch  = 1'b0;
			want_gear   = GEAR_2ND;
			want_clutch = 1'b0;
			blocked     = 1'b0;
			tmr_run     = 1'b0;
			tmr_count   = '0;
			tmr_limit   = '0;
			fails       = 0;
			pending_status.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SHIFT_DELAY:   shift_dly   = cfg_wdata;
					REG_RELEASE_DELAY: release_dly = cfg_wdata;
					REG_ENGAGE_DELAY:  engage_dly  = cfg_wdata;
					REG_DUTY_MAX:      duty_full   = cfg_wdata[DUTY_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_status.size() == 0) begin
					$error("result transaction with no expectation pending");
					fails++;
				end else begin
					exp = pending_status.pop_front();
					check_field("solenoid_a", exp.sol_a, solenoid_a);
					check_field("solenoid_b", exp.sol_b, solenoid_b);
					check_field("clutch_pwm", exp.duty, clutch_pwm);
					check_field("clutch_drive_on", exp.drive_on, clutch_drive_on);
					check_field("gear_now", exp.gear, gear_now);
					check_field("clutch_now", exp.clutch, clutch_now);
					check_field("busy_res", exp.busy, busy_res);
					check_field("status_gear", exp.want_gear, status_gear);
					check_field("status_clutch", exp.want_clutch, status_clutch);
					check_field("status_enabled", exp.en, status_enabled);
				end
			end
			if (in_valid && !in_stall) begin
				sequence_step(req_type, cmd_gear, cmd_clutch, enabled, res);
				pending_status.push_back(res);
			end
		end
		fail_count    <= fails;
		pending_count <= pending_status.size();
	end

endmodule

/* tb/gear_shift_clutch_sequencer_top_tb.sv */
`timescale 1ns / 100ps

module gear_shift_clutch_sequencer_top_tb;
	import gscs_pkg::*;

	// generous bound for a run of ~700 transactions
	localparam int CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_we      = 1'b0;
	logic [IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_W-1:0]  cfg_wdata   = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              req_type    = REQ_TICK;
	logic [GEAR_W-1:0] cmd_gear    = GEAR_1ST;
	logic              cmd_clutch  = 1'b0;
	logic              enabled     = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              solenoid_a;
	logic              solenoid_b;
	logic [DUTY_W-1:0] clutch_pwm;
	logic              clutch_drive_on;
	logic [GEAR_W-1:0] gear_now;
	logic              clutch_now;
	logic              busy_res;
	logic [GEAR_W-1:0] status_gear;
	logic              status_clutch;
	logic              status_enabled;

	int fail_count;
	int pending_count;
	int cycle_count  = 0;
	int tx_idle_pct  = 0;   // only touched by the stimulus process
	int rx_stall_pct = 0;   // read by the stall driver, so written with NBAs

	gear_shift_clutch_sequencer_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.cmd_gear        (cmd_gear),
		.cmd_clutch      (cmd_clutch),
		.enabled         (enabled),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.solenoid_a      (solenoid_a),
		.solenoid_b      (solenoid_b),
		.clutch_pwm      (clutch_pwm),
		.clutch_drive_on (clutch_drive_on),
		.gear_now        (gear_now),
		.clutch_now      (clutch_now),
		.busy_res        (busy_res),
		.status_gear     (status_gear),
		.status_clutch   (status_clutch),
		.status_enabled  (status_enabled)
	);

	// checker sits beside the block and sees the same pins
	gscs_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.cmd_gear        (cmd_gear),
		.cmd_clutch      (cmd_clutch),
		.enabled         (enabled),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.solenoid_a      (solenoid_a),
		.solenoid_b      (solenoid_b),
		.clutch_pwm      (clutch_pwm),
		.clutch_drive_on (clutch_drive_on),
		.gear_now        (gear_now),
		.clutch_now      (clutch_now),
		.busy_res        (busy_res),
		.status_gear     (status_gear),
		.status_clutch   (status_clutch),
		.status_enabled  (status_enabled),
		.fail_count      (fail_count),
		.pending_count   (pending_count)
	);

	// 12 ns period
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver back-pressure, random per cycle at the current rate
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one input transaction and hold it until it is taken. Sender gaps
	// are drawn per cycle before valid goes up; valid stays high across
	// back-to-back transactions without being dropped.
	task automatic send_item(input logic rt, input logic [GEAR_W-1:0] g, input logic c,
			input logic en);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rt;
		cmd_gear   <= g;
		cmd_clutch <= c;
		enabled    <= en;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// tick payload gear/clutch are don't-care, so randomize them
	task automatic send_tick(input logic en);
		send_item(REQ_TICK, GEAR_W'($urandom), 1'($urandom), en);
	endtask

	task automatic send_cmd(input logic [GEAR_W-1:0] g, input logic c, input logic en);
		send_item(REQ_CMD, g, c, en);
	endtask

	// Let every expected result come back, then cover the pipeline latency
	// before touching any register.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// cfg_we is left high between back-to-back writes; set_config drops it
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] shift_ticks,
			input logic [CFG_W-1:0] release_ticks, input logic [CFG_W-1:0] engage_ticks,
			input logic [DUTY_W-1:0] duty_top);
		wait_drained();
		write_reg(REG_SHIFT_DELAY, shift_ticks);
		write_reg(REG_RELEASE_DELAY, release_ticks);
		write_reg(REG_ENGAGE_DELAY, engage_ticks);
		// upper byte is junk; only the low byte belongs to duty_max
		write_reg(REG_DUTY_MAX, {8'($urandom), duty_top});
		cfg_we <= 1'b0;
	endtask

	// Mostly ticks so the delay timers run out and the sequencer keeps moving;
	// commands hit every gear, clutch mostly requested, enable mostly high.
	task automatic random_items(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 30)
				send_cmd(GEAR_W'($urandom), $urandom_range(0, 3) != 0,
					$urandom_range(0, 9) != 0);
			else
				send_tick($urandom_range(0, 9) != 0);
		end
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct <= rx_pct;
	endtask

	initial begin
		// reset held, then released once
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles 22%, receiver 70%
		set_idling(22, 70);

		// Reset configuration: long delays, so stay in second gear and only
		// start the non-blocking engage ramp. Early ramp duty truncates to
		// zero, so clutch_drive_on must read low while engaged.
		send_cmd(GEAR_2ND, 1'b1, 1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_cmd(GEAR_2ND, 1'b1, 1'b1);
		send_tick(1'b1);

		// Directed sequence with short delays and full duty
		set_config(16'd2, 16'd1, 16'd3, 8'd255);
		// first gear forces the clutch off -> release with blocking
		send_cmd(GEAR_1ST, 1'b1, 1'b1);
		// command while blocked: stored, acted on after the release delay
		send_cmd(GEAR_4TH, 1'b1, 1'b1);
		send_tick(1'b1);
		send_cmd(GEAR_3RD, 1'b0, 1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		// tick with the timer already stopped
		send_tick(1'b1);
		// engage ramp over three ticks, then held at duty_max
		send_cmd(GEAR_3RD, 1'b1, 1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		// disable drops the clutch
		send_cmd(GEAR_3RD, 1'b1, 1'b0);
		send_tick(1'b0);
		// downshift, then engage once the shift delay expires
		send_cmd(GEAR_2ND, 1'b1, 1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_cmd(GEAR_1ST, 1'b0, 1'b1);
		send_tick(1'b1);

		// random phases, sender idles 22%, receiver 70%
		set_config(16'd3, 16'd2, 16'd5, 8'd255);
		random_items(110);
		// all delays zero: timer ends at the next tick; zero duty_max keeps
		// clutch_drive_on low
		set_config(16'd0, 16'd0, 16'd0, 8'd0);
		random_items(80);

		// sender idles 70%, receiver 22%
		set_idling(70, 22);
		set_config(16'd1, 16'd1, 16'd1, 8'd100);
		random_items(110);
		set_config(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 6)),
			CFG_W'($urandom_range(1, 8)), DUTY_W'($urandom_range(0, 255)));
		random_items(110);

		// no idling on either side
		set_idling(0, 0);
		// longest engage ramp: duty climbs very slowly
		set_config(16'd2, 16'd3, 16'd65535, 8'd153);
		random_items(100);
		set_config(16'd4, 16'd4, 16'd7, 8'd1);
		random_items(110);
		// longest blocking delays last, since they cannot expire in this run
		set_config(16'd65535, 16'd65535, 16'd65535, 8'd255);
		random_items(40);

		// drain, then give the pipeline time to show any stray result
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
